// File: design/pia_pkg.sv
// Package for the two-port parallel interface adapter.
// Holds request and result types, operation codes and control register bits.
// Depends on nothing; used by pia_port and parallel_interface_adapter_unit.
`default_nettype none

package pia_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PINS  = 2'd2;
    localparam logic [1:0] OP_C1    = 2'd3;

    // Control register bit positions.
    localparam int CTL_C1_EN   = 0;
    localparam int CTL_C1_RISE = 1;
    localparam int CTL_OUT_SEL = 2;
    localparam int CTL_C2_EN   = 3;
    localparam int CTL_C2_DIR  = 4;
    localparam int CTL_C2_OUT  = 5;
    localparam int CTL_FLAG2   = 6;
    localparam int CTL_FLAG1   = 7;

    localparam logic [7:0] CTL_WMASK = 8'h3f;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] address;
        logic [7:0] write_data;
        logic [7:0] pin_value;
        logic       c1_level;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
        logic       ca2_pin;
        logic       cb2_pin;
    } t_out_item;

    // Request as seen by one port.
    typedef struct packed {
        logic [1:0] op;
        logic       ctl_sel;
        logic [7:0] write_data;
        logic [7:0] pin_value;
        logic       c1_level;
    } t_port_req;

    // Status of one port after the request.
    typedef struct packed {
        logic [7:0] rdata;
        logic [7:0] level;
        logic       irq;
        logic       c2;
    } t_port_stat;

    function automatic logic [7:0] pin_level(input logic [7:0] out_val,
                                             input logic [7:0] ddr,
                                             input logic [7:0] pins);
        pin_level = (out_val & ddr) | (pins & ~ddr);
    endfunction

endpackage

`default_nettype wire

// File: design/pia_port.sv
// One port of the parallel interface adapter: data, direction, control,
// input pin and C1 registers, with the next-state and status logic.
// Depends on pia_pkg.
`default_nettype none

module pia_port (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire pia_pkg::t_port_req  i_req,
    output pia_pkg::t_port_stat      o_stat
);

    logic [7:0] r_out, n_out;
    logic [7:0] r_ddr, n_ddr;
    logic [7:0] r_ctl, n_ctl;
    logic [7:0] r_pins, n_pins;
    logic       r_c1_last, n_c1_last;
    logic [7:0] rdata;

    always_comb begin
        n_out     = r_out;
        n_ddr     = r_ddr;
        n_ctl     = r_ctl;
        n_pins    = r_pins;
        n_c1_last = r_c1_last;
        rdata     = 8'h00;
        if (i_en) begin
            unique case (i_req.op)
                pia_pkg::OP_READ: begin
                    if (i_req.ctl_sel) begin
                        rdata = r_ctl;
                    end else if (!r_ctl[pia_pkg::CTL_OUT_SEL]) begin
                        rdata = r_ddr;
                    end else begin
                        // A data read acknowledges both interrupt flags.
                        n_ctl[pia_pkg::CTL_FLAG1] = 1'b0;
                        n_ctl[pia_pkg::CTL_FLAG2] = 1'b0;
                        rdata = pia_pkg::pin_level(r_out, r_ddr, r_pins);
                    end
                end
                pia_pkg::OP_WRITE: begin
                    if (i_req.ctl_sel) begin
                        n_ctl = (r_ctl & ~pia_pkg::CTL_WMASK) |
                                (i_req.write_data & pia_pkg::CTL_WMASK);
                    end else if (r_ctl[pia_pkg::CTL_OUT_SEL]) begin
                        n_out = i_req.write_data;
                    end else begin
                        n_ddr = i_req.write_data;
                    end
                end
                pia_pkg::OP_PINS: begin
                    n_pins = i_req.pin_value;
                end
                pia_pkg::OP_C1: begin
                    if (i_req.c1_level != r_c1_last) begin
                        n_c1_last = i_req.c1_level;
                        if (i_req.c1_level == r_ctl[pia_pkg::CTL_C1_RISE]) begin
                            n_ctl[pia_pkg::CTL_FLAG1] = 1'b1;
                        end
                    end
                end
                default: begin
                    rdata = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out     <= 8'h00;
            r_ddr     <= 8'h00;
            r_ctl     <= 8'h00;
            r_pins    <= 8'h00;
            r_c1_last <= 1'b0;
        end else begin
            r_out     <= n_out;
            r_ddr     <= n_ddr;
            r_ctl     <= n_ctl;
            r_pins    <= n_pins;
            r_c1_last <= n_c1_last;
        end
    end

    // Status reflects the register contents after this request.
    always_comb begin
        o_stat.rdata = rdata;
        o_stat.level = pia_pkg::pin_level(n_out, n_ddr, n_pins);
        o_stat.irq   = (n_ctl[pia_pkg::CTL_FLAG1] & n_ctl[pia_pkg::CTL_C1_EN]) |
                       (n_ctl[pia_pkg::CTL_FLAG2] & n_ctl[pia_pkg::CTL_C2_EN] &
                        ~n_ctl[pia_pkg::CTL_C2_OUT]);
        o_stat.c2    = n_ctl[pia_pkg::CTL_C2_OUT] & n_ctl[pia_pkg::CTL_C2_DIR] &
                       n_ctl[pia_pkg::CTL_C2_EN];
    end

    // Flag 2 can be cleared but nothing ever sets it.
    a_flag2_never_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ctl[pia_pkg::CTL_FLAG2] |=> !r_ctl[pia_pkg::CTL_FLAG2])
        else $error("flag 2 was set");

    // A control write leaves both flags alone.
    a_ctl_write_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_req.op == pia_pkg::OP_WRITE && i_req.ctl_sel)
        |=> $stable(r_ctl[7:6]))
        else $error("control write changed the flags");

    // The C1 history only moves on a C1 request.
    a_c1_last_only_on_c1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_en && i_req.op == pia_pkg::OP_C1) |=> $stable(r_c1_last))
        else $error("C1 history changed without a C1 request");

endmodule

`default_nettype wire

// File: design/parallel_interface_adapter_unit.sv
// Top level of the two-port parallel interface adapter: input register,
// port dispatch and result register. Depends on pia_pkg and pia_port.
//
// Usage: each request on i_item (accepted when i_valid is high and o_stall
// is low) is a bus read, a bus write, new pin levels or a new C1 level for
// the port chosen by address bit 1. Every request produces exactly one
// result on o_result (taken when o_valid is high and i_stall is low),
// carrying the read byte (zero for non-read requests), the interrupt line,
// both port levels and both C2 outputs as they stand after the request.
// Path: an accepted request is held in the input register, passes through
// the port logic and is captured in the result register.
// Throughput: one request per cycle while the receiver does not stall, set
// by the single pass through the port logic between the two registers.
// When the receiver stalls, the result register holds; the input register
// keeps accepting while it is empty and asserts o_stall once it is full.
// Reset (synchronous, active low) clears all port registers to zero and
// empties both pipeline registers.
`default_nettype none

module parallel_interface_adapter_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire pia_pkg::t_in_item   i_item,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output pia_pkg::t_out_item       o_result
);

    logic                r_in_vld;
    pia_pkg::t_in_item   r_in;
    logic                r_out_vld;
    pia_pkg::t_out_item  r_out, n_out;
    logic                adv;
    pia_pkg::t_port_req  port_req;
    pia_pkg::t_port_stat stat_a, stat_b;

    assign adv     = !r_out_vld || !i_stall;
    assign o_stall = r_in_vld && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_item;
        end
    end

    always_comb begin
        port_req.op         = r_in.op;
        port_req.ctl_sel    = r_in.address[0];
        port_req.write_data = r_in.write_data;
        port_req.pin_value  = r_in.pin_value;
        port_req.c1_level   = r_in.c1_level;
    end

    pia_port u_port_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_in_vld && adv && !r_in.address[1]),
        .i_req   (port_req),
        .o_stat  (stat_a)
    );

    pia_port u_port_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_in_vld && adv && r_in.address[1]),
        .i_req   (port_req),
        .o_stat  (stat_b)
    );

    always_comb begin
        n_out.read_data   = r_in.address[1] ? stat_b.rdata : stat_a.rdata;
        n_out.irq_out     = stat_a.irq | stat_b.irq;
        n_out.port_a_pins = stat_a.level;
        n_out.port_b_pins = stat_b.level;
        n_out.ca2_pin     = stat_a.c2;
        n_out.cb2_pin     = stat_b.c2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // A held result must back-pressure a full input register.
    a_stall_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall && r_in_vld) |-> o_stall)
        else $error("input stage advanced into a held result");

    // Only a bus read returns a nonzero byte.
    a_rdata_zero_non_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && adv && r_in.op != pia_pkg::OP_READ)
        |=> (o_valid && o_result.read_data == 8'h00))
        else $error("non-read request returned data");

    // A stalled result stays valid and unchanged.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
